// File: rtl/ept_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder position tracker package
// Command word, op and status codes, register indexes, reset values and limit constants.
// ----------------------------------------------------------------------------
package ept_pkg;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_MOTOR    = 2'd1,
      STATUS_BAD_LOOKBACK = 2'd2
   } status_type;

   localparam logic [7:0]  REG_HIGH_THRESHOLD   = 8'd0;
   localparam logic [7:0]  REG_LOW_THRESHOLD    = 8'd1;
   localparam logic [7:0]  HIGH_THRESHOLD_RESET = 8'd192;
   localparam logic [7:0]  LOW_THRESHOLD_RESET  = 8'd64;
   localparam logic [15:0] STOP_COUNT_MAX       = 16'hFFFF;
   localparam logic [31:0] PAST_NONE            = 32'hFFFF_FFFF;

   typedef struct packed {
      op_type     op;
      logic [7:0] motor;
      logic [7:0] raw_count;
      logic [7:0] lookback;
      logic       motor_bad;
      logic       lookback_bad;
   } cmd_type;

endpackage
`default_nettype wire

// File: rtl/ept_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder position tracker front end
// Accepts request words, classifies motor and lookback range, and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ept_front #(
   parameter int NUM_MOTORS    = 8,
   parameter int HISTORY_DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  logic            req_op,
   input  logic [7:0]      req_motor,
   input  logic [7:0]      req_raw_count,
   input  logic [7:0]      req_lookback,
   output logic            head_vld,
   output ept_pkg::cmd_type head_cmd,
   input  logic            head_pop
);
   import ept_pkg::*;

   cmd_type    q_mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;
   cmd_type    new_cmd;

   always_comb begin
      new_cmd.op           = op_type'(req_op);
      new_cmd.motor        = req_motor;
      new_cmd.raw_count    = req_raw_count;
      new_cmd.lookback     = req_lookback;
      new_cmd.motor_bad    = 9'(req_motor) >= 9'(NUM_MOTORS);
      new_cmd.lookback_bad = 9'(req_lookback) >= 9'(HISTORY_DEPTH);
   end

   assign full     = (count_ff == 2'd2);
   assign head_vld = (count_ff != 2'd0);
   assign head_cmd = q_mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = head_pop && head_vld;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> !do_pop)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count overflow");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers out of step");

endmodule
`default_nettype wire

// File: rtl/ept_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder position tracker back end
// Reads per-motor state from RAM, extends the raw count across wraps, updates
// speed, stop count and history ring, and holds the result word.
// ----------------------------------------------------------------------------
module ept_back #(
   parameter int NUM_MOTORS    = 8,
   parameter int HISTORY_DEPTH = 16,
   parameter int COUNTER_BITS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         high_threshold,
   input  logic [7:0]         low_threshold,
   input  logic               head_vld,
   input  ept_pkg::cmd_type   head_cmd,
   output logic               head_pop,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_abs_position,
   output logic signed [31:0] rsp_speed,
   output logic [15:0]        rsp_stopped_ticks,
   output logic signed [31:0] rsp_past_position
);
   import ept_pkg::*;

   localparam int MOT_W  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int PTR_W  = $clog2(HISTORY_DEPTH);
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [31:0] WRAP_STEP = 32'(1) << COUNTER_BITS;

   typedef struct packed {
      logic [COUNTER_BITS-1:0] last_raw;
      logic [31:0]             position;
      logic [31:0]             speed;
      logic [15:0]             stop_count;
      logic [PTR_W-1:0]        ptr;
      logic [FILL_W-1:0]       fill;
   } mstate_type;

   mstate_type       st_mem [NUM_MOTORS];
   logic [31:0]      hist_mem [NUM_MOTORS][HISTORY_DEPTH];

   logic             b1_vld_ff;
   cmd_type          b1_cmd_ff;
   mstate_type       st_rd_ff;
   logic             st_rd_vld_ff;
   logic [NUM_MOTORS-1:0] st_vld_ff;
   logic             last_vld_ff;
   logic [MOT_W-1:0] last_mot_ff;
   mstate_type       last_st_ff;
   logic [31:0]      hist_rd_ff;

   logic             b2_vld_ff;
   status_type       b2_status_ff;
   logic [31:0]      b2_pos_ff;
   logic [31:0]      b2_speed_ff;
   logic [15:0]      b2_stop_ff;
   logic             b2_self_ff;
   logic             b2_hvld_ff;

   logic             b2_go;
   logic             b1_go;
   logic [MOT_W-1:0] rd_mot;
   logic [MOT_W-1:0] b1_mot;
   logic             is_sample;
   logic             st_we;
   mstate_type       cur_st;
   mstate_type       upd_st;
   mstate_type       nxt_st;
   logic [15:0]      raw16;
   logic [COUNTER_BITS-1:0] raw_c;
   logic [15:0]      prev16;
   logic             wrap_up;
   logic             wrap_dn;
   logic [31:0]      pos_a;
   logic [9:0]       p10;
   logic [9:0]       n10;
   logic [9:0]       d10;
   logic [9:0]       idx10;
   logic [PTR_W-1:0] hidx;
   logic             hist_valid;
   logic             self_fwd;
   status_type       status_in;

   assign b2_go    = !b2_vld_ff || pop;
   assign b1_go    = b1_vld_ff && b2_go;
   assign head_pop = head_vld && (!b1_vld_ff || b2_go);
   assign rd_mot   = head_cmd.motor_bad ? '0 : head_cmd.motor[MOT_W-1:0];
   assign b1_mot   = b1_cmd_ff.motor[MOT_W-1:0];
   assign is_sample = (b1_cmd_ff.op == OP_SAMPLE) && !b1_cmd_ff.motor_bad;
   assign st_we    = b1_go && is_sample;

   always_comb begin
      if (last_vld_ff && (last_mot_ff == b1_mot)) begin
         cur_st = last_st_ff;
      end else if (st_rd_vld_ff) begin
         cur_st = st_rd_ff;
      end else begin
         cur_st = '0;
      end
   end

   always_comb begin
      raw16   = {8'h00, b1_cmd_ff.raw_count};
      raw_c   = raw16[COUNTER_BITS-1:0];
      prev16  = 16'(cur_st.last_raw);
      wrap_up = (prev16 > 16'(high_threshold)) && (16'(raw_c) < 16'(low_threshold));
      wrap_dn = (prev16 < 16'(low_threshold)) && (16'(raw_c) > 16'(high_threshold));
      pos_a   = cur_st.position + (wrap_up ? WRAP_STEP : 32'd0)
                - (wrap_dn ? WRAP_STEP : 32'd0);
      upd_st.last_raw = raw_c;
      upd_st.position = {pos_a[31:COUNTER_BITS], raw_c};
      upd_st.speed    = upd_st.position - cur_st.position;
      if (upd_st.speed == 32'd0) begin
         upd_st.stop_count = (cur_st.stop_count == STOP_COUNT_MAX) ?
                             cur_st.stop_count : cur_st.stop_count + 16'd1;
      end else begin
         upd_st.stop_count = 16'd0;
      end
      upd_st.ptr  = (10'(cur_st.ptr) == 10'(HISTORY_DEPTH - 1)) ?
                    '0 : cur_st.ptr + PTR_W'(1);
      upd_st.fill = (10'(cur_st.fill) == 10'(HISTORY_DEPTH)) ?
                    cur_st.fill : cur_st.fill + FILL_W'(1);
      nxt_st = is_sample ? upd_st : cur_st;
   end

   always_comb begin
      p10   = 10'(nxt_st.ptr);
      n10   = 10'(b1_cmd_ff.lookback);
      d10   = p10 - n10;
      idx10 = (p10 >= n10) ? d10 : d10 + 10'(HISTORY_DEPTH);
      hidx  = idx10[PTR_W-1:0];
      hist_valid = 10'(b1_cmd_ff.lookback) < 10'(nxt_st.fill);
      self_fwd   = is_sample && (b1_cmd_ff.lookback == 8'd0);
   end

   always_comb begin
      priority if (b1_cmd_ff.motor_bad) begin
         status_in = STATUS_BAD_MOTOR;
      end else if (b1_cmd_ff.lookback_bad) begin
         status_in = STATUS_BAD_LOOKBACK;
      end else begin
         status_in = STATUS_OK;
      end
   end

   // state and history RAMs, stage registers and the last-write bypass copy
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[b1_mot]         <= nxt_st;
         hist_mem[b1_mot][nxt_st.ptr] <= nxt_st.position;
      end
      if (head_pop) begin
         st_rd_ff     <= st_mem[rd_mot];
         st_rd_vld_ff <= st_vld_ff[rd_mot];
         b1_cmd_ff    <= head_cmd;
      end
      if (b1_go) begin
         hist_rd_ff   <= hist_mem[b1_mot][hidx];
         b2_status_ff <= status_in;
         b2_pos_ff    <= b1_cmd_ff.motor_bad ? 32'd0 : nxt_st.position;
         b2_speed_ff  <= b1_cmd_ff.motor_bad ? 32'd0 : nxt_st.speed;
         b2_stop_ff   <= b1_cmd_ff.motor_bad ? 16'd0 : nxt_st.stop_count;
         b2_self_ff   <= self_fwd;
         b2_hvld_ff   <= hist_valid;
      end
      if (st_we) begin
         last_mot_ff <= b1_mot;
         last_st_ff  <= nxt_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff   <= 1'b0;
         b2_vld_ff   <= 1'b0;
         last_vld_ff <= 1'b0;
         st_vld_ff   <= '0;
      end else begin
         if (head_pop) begin
            b1_vld_ff <= 1'b1;
         end else if (b1_go) begin
            b1_vld_ff <= 1'b0;
         end
         if (b1_go) begin
            b2_vld_ff <= 1'b1;
         end else if (pop) begin
            b2_vld_ff <= 1'b0;
         end
         if (st_we) begin
            last_vld_ff       <= 1'b1;
            st_vld_ff[b1_mot] <= 1'b1;
         end
      end
   end

   assign empty             = !b2_vld_ff;
   assign rsp_status        = b2_status_ff;
   assign rsp_abs_position  = b2_pos_ff;
   assign rsp_speed         = b2_speed_ff;
   assign rsp_stopped_ticks = b2_stop_ff;

   always_comb begin
      priority if (b2_status_ff == STATUS_BAD_MOTOR) begin
         rsp_past_position = 32'd0;
      end else if (b2_status_ff == STATUS_BAD_LOOKBACK) begin
         rsp_past_position = PAST_NONE;
      end else if (b2_self_ff) begin
         rsp_past_position = b2_pos_ff;
      end else if (b2_hvld_ff) begin
         rsp_past_position = hist_rd_ff;
      end else begin
         rsp_past_position = 32'd0;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      b1_vld_ff |-> (10'(cur_st.fill) <= 10'(HISTORY_DEPTH)))
      else $error("history fill above depth");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      b1_vld_ff |-> (10'(cur_st.ptr) < 10'(HISTORY_DEPTH)))
      else $error("ring pointer out of range");

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      st_we |=> last_vld_ff)
      else $error("state forward not armed");

   a_self_ok: assert property (@(posedge clock) disable iff (reset)
      (b2_vld_ff && b2_self_ff) |-> (b2_status_ff == STATUS_OK))
      else $error("self forward on bad status");

   a_bad_motor_zero: assert property (@(posedge clock) disable iff (reset)
      (b2_vld_ff && (b2_status_ff == STATUS_BAD_MOTOR)) |->
      ((b2_pos_ff == 32'd0) && (b2_speed_ff == 32'd0) && (b2_stop_ff == 16'd0)))
      else $error("bad motor result not cleared");

endmodule
`default_nettype wire

// File: rtl/encoder_position_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request passes the queue, then the state RAM read register,
// then the update into the result register that drives the result ports.
// Throughput: one word per cycle unless pop stalls; registered per-motor state
// RAM reads use the last write, so back-to-back words on one motor do not stall.
// Reset: thresholds return to 192 and 64; per-motor state and history fill
// counts clear at once through valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Encoder position tracker top level
// Threshold registers, request front end and execution back end.
// ----------------------------------------------------------------------------
module encoder_position_tracker_top #(
   parameter int NUM_MOTORS    = 8,
   parameter int HISTORY_DEPTH = 16,
   parameter int COUNTER_BITS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_op,
   input  logic [7:0]         req_motor,
   input  logic [7:0]         req_raw_count,
   input  logic [7:0]         req_lookback,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_abs_position,
   output logic signed [31:0] rsp_speed,
   output logic [15:0]        rsp_stopped_ticks,
   output logic signed [31:0] rsp_past_position,
   input  logic               valid,
   output logic               ready,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_wdata
);
   import ept_pkg::*;

   logic       high_thr_ff;
   logic [7:0] high_threshold_ff;
   logic [7:0] low_threshold_ff;
   logic       head_vld;
   cmd_type    head_cmd;
   logic       head_pop;

   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_threshold_ff <= HIGH_THRESHOLD_RESET;
         low_threshold_ff  <= LOW_THRESHOLD_RESET;
      end else if (valid && ready) begin
         if (csr_index == REG_HIGH_THRESHOLD) begin
            high_threshold_ff <= csr_wdata;
         end else if (csr_index == REG_LOW_THRESHOLD) begin
            low_threshold_ff <= csr_wdata;
         end
      end
   end

   // track a high threshold write for the check below
   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff <= 1'b0;
      end else begin
         high_thr_ff <= valid && (csr_index == REG_HIGH_THRESHOLD);
      end
   end

   ept_front #(
      .NUM_MOTORS    (NUM_MOTORS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_motor       (req_motor),
      .req_raw_count   (req_raw_count),
      .req_lookback    (req_lookback),
      .head_vld        (head_vld),
      .head_cmd        (head_cmd),
      .head_pop        (head_pop)
   );

   ept_back #(
      .NUM_MOTORS    (NUM_MOTORS),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COUNTER_BITS  (COUNTER_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .high_threshold    (high_threshold_ff),
      .low_threshold     (low_threshold_ff),
      .head_vld          (head_vld),
      .head_cmd          (head_cmd),
      .head_pop          (head_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_abs_position  (rsp_abs_position),
      .rsp_speed         (rsp_speed),
      .rsp_stopped_ticks (rsp_stopped_ticks),
      .rsp_past_position (rsp_past_position)
   );

   a_high_written: assert property (@(posedge clock) disable iff (reset)
      high_thr_ff |-> (high_threshold_ff == $past(csr_wdata)))
      else $error("high threshold write lost");

   a_low_held: assert property (@(posedge clock) disable iff (reset)
      ($past(!valid) && !$past(reset)) |-> $stable(low_threshold_ff))
      else $error("low threshold changed without write");

   a_full_blocks_issue: assert property (@(posedge clock) disable iff (reset)
      full |-> head_vld)
      else $error("full queue without head word");

endmodule
`default_nettype wire

// File: test/tb_encoder_position_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder position tracker testbench
// Drives sample and query words into the tracker under random sender and
// receiver idling and a long receiver hold-off, and tracks every motor's
// position, speed, stopped count and history ring alongside the block. Each
// result word is checked field by field against the tracked values; the
// threshold registers are swept between phases and one motor is held still
// so that its stopped count climbs.
// ----------------------------------------------------------------------------
module tb_encoder_position_tracker_top;
   import ept_pkg::*;

   localparam int MOTOR_COUNT  = 8;
   localparam int HIST_DEPTH   = 16;
   localparam int WRAP_STEP    = 256;
   localparam int BACKLOG_MAX  = 32;
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_HOLD    = 300;
   localparam int STILL_WORDS  = 39;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct {
      op_type     op;
      logic [7:0] motor;
      logic [7:0] raw;
      logic [7:0] lookback;
   } encoder_cmd_type;

   typedef struct {
      status_type         status;
      logic signed [31:0] position;
      logic signed [31:0] speed;
      logic [15:0]        stopped;
      logic signed [31:0] past;
   } readback_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic               req_op = 1'b0;
   logic [7:0]         req_motor = 8'd0;
   logic [7:0]         req_raw_count = 8'd0;
   logic [7:0]         req_lookback = 8'd0;
   logic               empty;
   logic               pop = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_abs_position;
   logic signed [31:0] rsp_speed;
   logic [15:0]        rsp_stopped_ticks;
   logic signed [31:0] rsp_past_position;
   logic               valid = 1'b0;
   logic               ready;
   logic [7:0]         csr_index = 8'd0;
   logic [7:0]         csr_wdata = 8'd0;

   // tracked copy of the block's registers and per-motor state
   logic [7:0]  high_thr = HIGH_THRESHOLD_RESET;
   logic [7:0]  low_thr  = LOW_THRESHOLD_RESET;
   logic [7:0]  last_raw  [MOTOR_COUNT];
   logic [31:0] motor_pos [MOTOR_COUNT];
   logic [31:0] motor_spd [MOTOR_COUNT];
   logic [15:0] stop_ticks[MOTOR_COUNT];
   logic [3:0]  ring_ptr  [MOTOR_COUNT];
   logic [31:0] pos_ring  [MOTOR_COUNT][HIST_DEPTH];

   encoder_cmd_type req_backlog[$];
   readback_type    predicted_readbacks[$];

   int  walk_raw[MOTOR_COUNT];
   int  idle_mode = 0;
   int  mismatches = 0;
   int  checked_words = 0;
   int  cycle_count = 0;
   int  hold_cycles = 0;
   int  n_samples = 0, n_queries = 0, n_bad_motor = 0, n_bad_lookback = 0;
   int  n_wrap_up = 0, n_wrap_down = 0, n_saturated = 0;
   bit  word_accepted = 1'b0;
   bit  stall_armed = 1'b0;

   encoder_position_tracker_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_op            (req_op),
      .req_motor         (req_motor),
      .req_raw_count     (req_raw_count),
      .req_lookback      (req_lookback),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_abs_position  (rsp_abs_position),
      .rsp_speed         (rsp_speed),
      .rsp_stopped_ticks (rsp_stopped_ticks),
      .rsp_past_position (rsp_past_position),
      .valid             (valid),
      .ready             (ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // advance one motor's tracked state for a word and return its readback
   function automatic readback_type track_motor(encoder_cmd_type cmd);
      readback_type rb;
      logic [2:0]  m;
      logic [7:0]  prev_raw;
      logic [31:0] prev_pos;
      logic [31:0] pos;
      rb.status   = STATUS_OK;
      rb.position = '0;
      rb.speed    = '0;
      rb.stopped  = '0;
      rb.past     = '0;
      if (cmd.motor >= MOTOR_COUNT) begin
         rb.status = STATUS_BAD_MOTOR;
         n_bad_motor++;
         return rb;
      end
      m = cmd.motor[2:0];
      if (cmd.op == OP_SAMPLE) begin
         n_samples++;
         prev_raw = last_raw[m];
         prev_pos = motor_pos[m];
         pos = prev_pos;
         last_raw[m] = cmd.raw;
         if (prev_raw > high_thr && cmd.raw < low_thr) begin
            pos = pos + WRAP_STEP;
            n_wrap_up++;
         end
         if (prev_raw < low_thr && cmd.raw > high_thr) begin
            pos = pos - WRAP_STEP;
            n_wrap_down++;
         end
         pos = {pos[31:8], cmd.raw};
         motor_pos[m] = pos;
         ring_ptr[m] = ring_ptr[m] + 4'd1;
         pos_ring[m][ring_ptr[m]] = pos;
         motor_spd[m] = pos - prev_pos;
         if (motor_spd[m] == 32'd0) begin
            if (stop_ticks[m] != STOP_COUNT_MAX)
               stop_ticks[m] = stop_ticks[m] + 16'd1;
            else
               n_saturated++;
         end else begin
            stop_ticks[m] = '0;
         end
      end else begin
         n_queries++;
      end
      if (cmd.lookback >= HIST_DEPTH) begin
         rb.status = STATUS_BAD_LOOKBACK;
         rb.past   = PAST_NONE;
         n_bad_lookback++;
      end else begin
         rb.past = pos_ring[m][ring_ptr[m] - cmd.lookback[3:0]];
      end
      rb.position = motor_pos[m];
      rb.speed    = motor_spd[m];
      rb.stopped  = stop_ticks[m];
      return rb;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch on %s, word %0d: got %08h, expected %08h",
                  field, checked_words, got, want);
   endtask

   function automatic bit sender_idles();
      case (idle_mode)
         0: return $urandom_range(0, 99) < 36;
         1: return $urandom_range(0, 99) < 50;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_idles();
      case (idle_mode)
         0: return $urandom_range(0, 99) < 50;
         1: return $urandom_range(0, 99) < 36;
         default: return 1'b0;
      endcase
   endfunction

   // request driver: hold the offered word until taken, then advance
   always @(negedge clock) begin : driver
      bit taken;
      taken = word_accepted;
      if (word_accepted) begin
         void'(req_backlog.pop_front());
         word_accepted = 1'b0;
      end
      if (reset) begin
         push <= 1'b0;
      end else if (!push || taken) begin
         if (req_backlog.size() > 0 && !sender_idles()) begin
            req_op          <= req_backlog[0].op;
            req_motor       <= req_backlog[0].motor;
            req_raw_count   <= req_backlog[0].raw;
            req_lookback    <= req_backlog[0].lookback;
            push            <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // result pacing, with one long hold-off when armed
   always @(negedge clock) begin : receiver
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (stall_armed) begin
            hold_cycles = LONG_HOLD;
            stall_armed = 1'b0;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            pop <= 1'b0;
         end else begin
            pop <= !receiver_idles();
         end
      end
   end

   always @(posedge clock) begin : monitor
      encoder_cmd_type cmd;
      readback_type    want;
      if (!reset) begin
         if (push && !full) begin
            cmd.op       = op_type'(req_op);
            cmd.motor    = req_motor;
            cmd.raw      = req_raw_count;
            cmd.lookback = req_lookback;
            predicted_readbacks.push_back(track_motor(cmd));
            word_accepted = 1'b1;
         end
         if (pop && !empty) begin
            checked_words++;
            if (predicted_readbacks.size() == 0) begin
               report_mismatch("unexpected word", {30'd0, rsp_status}, '0);
            end else begin
               want = predicted_readbacks.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
               if (rsp_abs_position !== want.position)
                  report_mismatch("abs_position", rsp_abs_position, want.position);
               if (rsp_speed !== want.speed)
                  report_mismatch("speed", rsp_speed, want.speed);
               if (rsp_stopped_ticks !== want.stopped)
                  report_mismatch("stopped_ticks", {16'd0, rsp_stopped_ticks},
                                  {16'd0, want.stopped});
               if (rsp_past_position !== want.past)
                  report_mismatch("past_position", rsp_past_position, want.past);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, predicted_readbacks.size());
         $display("tb_encoder_position_tracker_top NOT OK");
         $finish;
      end
   end

   task automatic offer(op_type op, logic [7:0] motor, logic [7:0] raw, logic [7:0] lookback);
      encoder_cmd_type cmd;
      cmd.op       = op;
      cmd.motor    = motor;
      cmd.raw      = raw;
      cmd.lookback = lookback;
      while (req_backlog.size() >= BACKLOG_MAX)
         @(negedge clock);
      req_backlog.push_back(cmd);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [7:0] data);
      @(negedge clock);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!ready);
      if (idx == REG_HIGH_THRESHOLD)
         high_thr = data;
      else if (idx == REG_LOW_THRESHOLD)
         low_thr = data;
      @(negedge clock);
      valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || push || predicted_readbacks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed words; raw counts walk so that wraps happen often
   task automatic random_words(int count);
      op_type     op;
      logic [7:0] motor;
      logic [7:0] raw;
      logic [7:0] lookback;
      int         m;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_SAMPLE;
         motor = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(8, 255))
                                              : 8'($urandom_range(0, 7));
         lookback = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 15));
         m = motor % MOTOR_COUNT;
         if ($urandom_range(0, 7) == 0)
            walk_raw[m] = $urandom_range(0, 255);
         else
            walk_raw[m] = (walk_raw[m] + WRAP_STEP + $urandom_range(0, 96) - 48) % WRAP_STEP;
         raw = 8'(walk_raw[m]);
         offer(op, motor, raw, lookback);
      end
   endtask

   initial begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         last_raw[m]   = '0;
         motor_pos[m]  = '0;
         motor_spd[m]  = '0;
         stop_ticks[m] = '0;
         ring_ptr[m]   = '0;
         walk_raw[m]   = 0;
         for (int i = 0; i < HIST_DEPTH; i++)
            pos_ring[m][i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at reset thresholds
      idle_mode = 0;
      offer(OP_QUERY,  8'd0,   8'd0,   8'd0);
      offer(OP_SAMPLE, 8'd0,   8'd0,   8'd0);
      offer(OP_SAMPLE, 8'd0,   8'd255, 8'd1);
      offer(OP_SAMPLE, 8'd0,   8'd0,   8'd2);
      offer(OP_SAMPLE, 8'd0,   8'd0,   8'd15);
      offer(OP_SAMPLE, 8'd0,   8'd0,   8'd16);
      offer(OP_QUERY,  8'd0,   8'd0,   8'd255);
      offer(OP_SAMPLE, 8'd7,   8'd128, 8'd0);
      offer(OP_SAMPLE, 8'd8,   8'hAA,  8'h55);
      offer(OP_QUERY,  8'd255, 8'h55,  8'hAA);
      offer(OP_QUERY,  8'd7,   8'd255, 8'd0);
      offer(OP_SAMPLE, 8'd1,   8'd200, 8'd0);
      offer(OP_SAMPLE, 8'd1,   8'd10,  8'd1);
      offer(OP_SAMPLE, 8'd1,   8'd63,  8'd0);
      offer(OP_SAMPLE, 8'd1,   8'd193, 8'd0);
      offer(OP_SAMPLE, 8'd1,   8'd64,  8'd0);
      offer(OP_SAMPLE, 8'd1,   8'd192, 8'd0);
      offer(OP_QUERY,  8'd1,   8'd0,   8'd5);
      offer(OP_SAMPLE, 8'd2,   8'h55,  8'h0A);
      offer(OP_SAMPLE, 8'd2,   8'hAA,  8'h05);
      wait_drained();

      // thresholds at their extremes: no wrap can fire
      write_csr(REG_HIGH_THRESHOLD, 8'd255);
      write_csr(REG_LOW_THRESHOLD, 8'd0);
      write_csr(8'd2, 8'h5A);
      write_csr(8'd255, 8'hFF);
      random_words(130);
      wait_drained();

      // inverted thresholds: both wrap rules can fire on one sample
      idle_mode = 1;
      write_csr(REG_HIGH_THRESHOLD, 8'd0);
      write_csr(REG_LOW_THRESHOLD, 8'd255);
      random_words(130);
      wait_drained();

      // random thresholds, no idling, one long receiver hold-off
      idle_mode = 2;
      write_csr(REG_HIGH_THRESHOLD, 8'($urandom_range(128, 250)));
      write_csr(REG_LOW_THRESHOLD, 8'($urandom_range(5, 127)));
      stall_armed = 1'b1;
      random_words(130);
      wait_drained();

      // reset thresholds; hold one motor still so its stopped count climbs
      write_csr(REG_HIGH_THRESHOLD, HIGH_THRESHOLD_RESET);
      write_csr(REG_LOW_THRESHOLD, LOW_THRESHOLD_RESET);
      for (int i = 0; i < STILL_WORDS; i++)
         offer(OP_SAMPLE, 8'd6, 8'd100, ($urandom_range(0, 7) == 0) ? 8'd200
                                                                   : 8'($urandom_range(0, 15)));
      offer(OP_QUERY, 8'd6, 8'd0, 8'd3);
      wait_drained();

      $display("covered %0d samples and %0d queries, %0d bad motor and %0d bad lookback words",
               n_samples, n_queries, n_bad_motor, n_bad_lookback);
      $display("saw %0d forward and %0d backward wraps, %0d samples at stopped-count saturation",
               n_wrap_up, n_wrap_down, n_saturated);
      if (mismatches == 0 && predicted_readbacks.size() == 0) begin
         $display("tb_encoder_position_tracker_top OK");
      end else begin
         $display("tb_encoder_position_tracker_top NOT OK");
      end
      $finish;
   end

endmodule
